### rtl/core/gif_lzw_decoder_assert.svh
// Assertion macros for the GIF LZW decoder; they sample on clock and
// are disabled while reset is high.
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH

// Same-cycle implication.
`define GLD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gif_lzw assertion failed");

// Next-cycle implication.
`define GLD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gif_lzw assertion failed");

`endif

### rtl/core/gif_lzw_pkg.sv
`default_nettype none
package gif_lzw_pkg;

   localparam int CODE_W = 12;
   localparam int NF_W   = 13;
   localparam int CW_W   = 4;
   localparam int BUF_W  = 24;
   localparam int CNT_W  = 5;
   localparam int SIZE_W = 4;

   localparam logic [1:0] FN_PUSH    = 2'd0;
   localparam logic [1:0] FN_FETCH   = 2'd1;
   localparam logic [1:0] FN_RESTART = 2'd2;

   typedef enum logic [2:0] {
      ST_PIXEL     = 3'd0,
      ST_ACCEPTED  = 3'd1,
      ST_REFUSED   = 3'd2,
      ST_NEED      = 3'd3,
      ST_END       = 3'd4,
      ST_ERROR     = 3'd5,
      ST_RESTARTED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      RD_NONE   = 3'd0,
      RD_CODE   = 3'd1,
      RD_PREV   = 3'd2,
      RD_WALK   = 3'd3,
      RD_PARENT = 3'd4
   } rd_sel_type;

   typedef struct packed {
      logic [11:0] parent;
      logic [11:0] len;
      logic [7:0]  first_ch;
      logic [7:0]  last_ch;
   } entry_type;

   typedef struct packed {
      logic       push;
      logic       restart;
      logic       sweep_wr;
      logic       clear_sp;
      logic       pop;
      logic       take_code;
      logic       set_ended;
      logic       do_clear;
      logic       set_failed;
      logic       clr_after;
      logic       set_prev;
      logic       set_ch;
      logic       set_kwk;
      logic       kwk_val;
      logic       add_wr;
      logic       walk_code;
      logic       push_char;
      rd_sel_type rd_sel;
      logic       res_ld;
      logic       res_pix;
      status_type res_status;
   } cmd_type;

   typedef struct packed {
      logic failed;
      logic sp_nz;
      logic ended;
      logic no_code;
      logic buf_full;
      logic size_ok;
      logic is_end;
      logic is_clear;
      logic after_clear;
      logic code_ge_nf;
      logic prev_ge_nf;
      logic tbl_full;
      logic len_le1;
      logic sp_full;
      logic sweep_last;
   } sts_type;

   function automatic logic [11:0] last_code_of_width(input logic [3:0] cw);
      logic [11:0] r;
      case (cw)
         4'd3:    r = 12'd7;
         4'd4:    r = 12'd15;
         4'd5:    r = 12'd31;
         4'd6:    r = 12'd63;
         4'd7:    r = 12'd127;
         4'd8:    r = 12'd255;
         4'd9:    r = 12'd511;
         4'd10:   r = 12'd1023;
         4'd11:   r = 12'd2047;
         4'd12:   r = 12'd4095;
         default: r = 12'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/gif_lzw_req_if.sv
`default_nettype none
interface gif_lzw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;
   modport source (output valid, output func, output data_byte, input ready);
   modport sink (input valid, input func, input data_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/gif_lzw_rsp_if.sv
`default_nettype none
interface gif_lzw_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] pixel_index;
   logic       last_of_code;
   modport source (output valid, output status, output pixel_index, output last_of_code,
                   input ready);
   modport sink (input valid, input status, input pixel_index, input last_of_code,
                 output ready);
endinterface
`default_nettype wire

### rtl/core/gif_lzw_decoder.sv
// Push, restart with a bad size and unused codes: result registered on transfer, sent via S_EMIT.
// Fetch of a pending pixel: S_FETCH pops (stack read is registered), S_POP loads, S_EMIT sends.
// Fetch that decodes: S_DECODE reads a code, then S_WALK stacks its string (dictionary walk).
// Restart with a valid size sweeps the 2^size root entries before the answer is sent.
// Reset (synchronous, active high) runs a sweep of the 256 root entries; no transfer is taken meanwhile.
// One item in flight; a finished result may wait in the output register while the next is taken.
`default_nettype none
module gif_lzw_decoder #(
   parameter int unsigned DICT_ENTRIES  = 4096,
   parameter int unsigned MAX_CODE_BITS = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   gif_lzw_req_if.sink        req_if,
   gif_lzw_rsp_if.source      rsp_if,
   input  wire logic          csr_we,
   input  wire logic [3:0]    csr_wdata
);
   gif_lzw_pkg::cmd_type cmd;
   gif_lzw_pkg::sts_type sts;

   logic       emit, out_free;
   logic [2:0] res_status;
   logic [7:0] res_pixel;
   logic       res_last;

   // output register: hold a result until the sink takes the transfer
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff;
   logic [7:0] rsp_pixel_ff;
   logic       rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   gif_lzw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .out_free  (out_free),
      .sts       (sts),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .emit      (emit)
   );

   gif_lzw_dp #(
      .DICT_ENTRIES  (DICT_ENTRIES),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_byte   (req_if.data_byte),
      .sts        (sts),
      .res_status (res_status),
      .res_pixel  (res_pixel),
      .res_last   (res_last)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   // load the payload only when a new result is released
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= res_status;
         rsp_pixel_ff  <= res_pixel;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.pixel_index  = rsp_pixel_ff;
   assign rsp_if.last_of_code = rsp_last_ff;
endmodule
`default_nettype wire

### rtl/core/gif_lzw_dp.sv
`default_nettype none
module gif_lzw_dp #(
   parameter int unsigned DICT_ENTRIES  = 4096,
   parameter int unsigned MAX_CODE_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gif_lzw_pkg::cmd_type   cmd,
   input  wire logic                   csr_we,
   input  wire logic [3:0]             csr_wdata,
   input  wire logic [7:0]             req_byte,
   output gif_lzw_pkg::sts_type        sts,
   output logic [2:0]                  res_status,
   output logic [7:0]                  res_pixel,
   output logic                        res_last
);
   localparam int AW  = $clog2(DICT_ENTRIES);
   localparam int SPW = AW + 1;

   gif_lzw_pkg::entry_type ent_mem [DICT_ENTRIES];
   logic [7:0]             stk_mem [DICT_ENTRIES];

   logic [3:0]  size_ff, size_in, swp_size_ff, swp_size_in;
   logic [AW-1:0] swp_idx_ff, swp_idx_in, walk_ff, walk_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        ended_ff, ended_in, failed_ff, failed_in, after_ff, after_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [11:0] prev_ff, prev_in, code_ff, code_in;
   logic [12:0] nf_ff, nf_in;
   logic [3:0]  cw_ff, cw_in;
   logic [7:0]  ch_ff, ch_in;
   logic        kwk_ff, kwk_in, last_ff, last_in;
   logic [2:0]  res_status_ff, res_status_in;
   logic [7:0]  res_pixel_ff, res_pixel_in;
   logic        res_last_ff, res_last_in;

   gif_lzw_pkg::entry_type rd_data_ff;
   logic [7:0]             stk_rd_ff;

   logic [16:0]   roots_live, roots_swp;
   logic [11:0]   code_mask;
   logic [AW-1:0] roots_m1, rd_addr;
   logic          size_ok, grow;

   always_comb begin
      roots_live = 17'd1 << size_ff;
      roots_swp  = 17'd1 << swp_size_ff;
      roots_m1   = AW'(roots_swp - 17'd1);
      code_mask  = 12'((16'd1 << cw_ff) - 16'd1);
      size_ok    = (size_ff >= 4'd2) && ((5'(size_ff) + 5'd1) <= 5'(MAX_CODE_BITS)) &&
                   ((roots_live + 17'd2) <= 17'(DICT_ENTRIES));
      grow       = (cw_ff < 4'(MAX_CODE_BITS)) && (cw_ff <= 4'd12) &&
                   (nf_ff == 13'(gif_lzw_pkg::last_code_of_width(cw_ff)));

      sts.failed      = failed_ff;
      sts.sp_nz       = sp_ff != '0;
      sts.ended       = ended_ff;
      sts.no_code     = (cw_ff == 4'd0) || (cw_ff > 4'd12) || (5'(cw_ff) > cnt_ff);
      sts.buf_full    = cnt_ff > 5'd16;
      sts.size_ok     = size_ok;
      sts.is_end      = 17'(code_ff) == (roots_live + 17'd1);
      sts.is_clear    = 17'(code_ff) == roots_live;
      sts.after_clear = after_ff;
      sts.code_ge_nf  = 13'(code_ff) >= nf_ff;
      sts.prev_ge_nf  = 13'(prev_ff) >= nf_ff;
      sts.tbl_full    = nf_ff >= 13'(DICT_ENTRIES);
      sts.len_le1     = rd_data_ff.len <= 12'd1;
      sts.sp_full     = sp_ff == SPW'(DICT_ENTRIES);
      sts.sweep_last  = swp_idx_ff == roots_m1;

      case (cmd.rd_sel)
         gif_lzw_pkg::RD_CODE:   rd_addr = code_ff[AW-1:0];
         gif_lzw_pkg::RD_PREV:   rd_addr = prev_ff[AW-1:0];
         gif_lzw_pkg::RD_WALK:   rd_addr = walk_ff;
         gif_lzw_pkg::RD_PARENT: rd_addr = rd_data_ff.parent[AW-1:0];
         default:                rd_addr = '0;
      endcase
   end

   always_comb begin
      size_in       = csr_we ? csr_wdata : size_ff;
      swp_size_in   = swp_size_ff;
      swp_idx_in    = swp_idx_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      ended_in      = ended_ff;
      failed_in     = failed_ff;
      after_in      = after_ff;
      sp_in         = sp_ff;
      prev_in       = prev_ff;
      code_in       = code_ff;
      nf_in         = nf_ff;
      cw_in         = cw_ff;
      ch_in         = ch_ff;
      kwk_in        = kwk_ff;
      walk_in       = walk_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_pixel_in  = res_pixel_ff;
      res_last_in   = res_last_ff;

      if (cmd.restart) begin
         buf_in      = '0;
         cnt_in      = '0;
         ended_in    = 1'b0;
         failed_in   = !size_ok;
         sp_in       = '0;
         prev_in     = '0;
         after_in    = 1'b1;
         nf_in       = size_ok ? 13'(roots_live + 17'd2) : 13'd0;
         cw_in       = size_ok ? 4'(size_ff + 4'd1) : 4'd0;
         swp_size_in = size_ff;
         swp_idx_in  = '0;
      end
      if (cmd.sweep_wr) swp_idx_in = swp_idx_ff + AW'(1);
      if (cmd.push && !sts.buf_full) begin
         buf_in = buf_ff | (24'(req_byte) << cnt_ff);
         cnt_in = cnt_ff + 5'd8;
      end
      if (cmd.take_code) begin
         code_in = buf_ff[11:0] & code_mask;
         buf_in  = buf_ff >> cw_ff;
         cnt_in  = cnt_ff - 5'(cw_ff);
      end
      if (cmd.clear_sp)   sp_in = '0;
      if (cmd.pop) begin
         sp_in   = sp_ff - SPW'(1);
         last_in = sp_ff == SPW'(1);
      end
      if (cmd.push_char)  sp_in = sp_ff + SPW'(1);
      if (cmd.set_ended)  ended_in = 1'b1;
      if (cmd.set_failed) failed_in = 1'b1;
      if (cmd.do_clear) begin
         nf_in    = 13'(roots_live + 17'd2);
         cw_in    = 4'(size_ff + 4'd1);
         after_in = 1'b1;
         prev_in  = '0;
      end
      if (cmd.clr_after) after_in = 1'b0;
      if (cmd.set_prev)  prev_in = code_ff;
      if (cmd.set_ch)    ch_in = rd_data_ff.first_ch;
      if (cmd.set_kwk)   kwk_in = cmd.kwk_val;
      if (cmd.walk_code) walk_in = code_ff[AW-1:0];
      if (cmd.add_wr) begin
         nf_in   = nf_ff + 13'd1;
         walk_in = kwk_ff ? nf_ff[AW-1:0] : code_ff[AW-1:0];
         if (grow) cw_in = cw_ff + 4'd1;
      end
      if (cmd.res_ld) begin
         res_status_in = cmd.res_status;
         res_pixel_in  = cmd.res_pix ? stk_rd_ff : 8'd0;
         res_last_in   = cmd.res_pix ? last_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= 4'd8;
         swp_size_ff <= 4'd8;
         swp_idx_ff  <= '0;
         buf_ff      <= '0;
         cnt_ff      <= '0;
         ended_ff    <= 1'b0;
         failed_ff   <= 1'b0;
         after_ff    <= 1'b1;
         sp_ff       <= '0;
         prev_ff     <= '0;
         nf_ff       <= 13'd258;
         cw_ff       <= 4'd9;
      end else begin
         size_ff     <= size_in;
         swp_size_ff <= swp_size_in;
         swp_idx_ff  <= swp_idx_in;
         buf_ff      <= buf_in;
         cnt_ff      <= cnt_in;
         ended_ff    <= ended_in;
         failed_ff   <= failed_in;
         after_ff    <= after_in;
         sp_ff       <= sp_in;
         prev_ff     <= prev_in;
         nf_ff       <= nf_in;
         cw_ff       <= cw_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      ch_ff         <= ch_in;
      kwk_ff        <= kwk_in;
      walk_ff       <= walk_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_pixel_ff  <= res_pixel_in;
      res_last_ff   <= res_last_in;
   end

   // dictionary: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.sweep_wr) begin
         ent_mem[swp_idx_ff] <= '{parent: 12'd0, len: 12'd1,
                                  first_ch: 8'(swp_idx_ff), last_ch: 8'(swp_idx_ff)};
      end else if (cmd.add_wr) begin
         ent_mem[nf_ff[AW-1:0]] <= '{parent: prev_ff,
                                     len: 12'(rd_data_ff.len + 12'd1),
                                     first_ch: rd_data_ff.first_ch,
                                     last_ch: kwk_ff ? rd_data_ff.first_ch : ch_ff};
      end
      if (cmd.rd_sel != gif_lzw_pkg::RD_NONE) rd_data_ff <= ent_mem[rd_addr];
   end

   // string stack
   always_ff @(posedge clock) begin
      if (cmd.push_char) stk_mem[sp_ff[AW-1:0]] <= rd_data_ff.last_ch;
      if (cmd.pop) stk_rd_ff <= stk_mem[AW'(sp_ff - SPW'(1))];
   end

   assign res_status = res_status_ff;
   assign res_pixel  = res_pixel_ff;
   assign res_last   = res_last_ff;
endmodule
`default_nettype wire

### rtl/core/gif_lzw_ctrl.sv
`default_nettype none
`include "gif_lzw_decoder_assert.svh"
module gif_lzw_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_func,
   input  wire logic                  out_free,
   input  wire gif_lzw_pkg::sts_type  sts,
   output logic                       req_ready,
   output gif_lzw_pkg::cmd_type       cmd,
   output logic                       emit
);
   typedef enum logic [9:0] {
      S_SWEEP  = 10'b00_0000_0001,
      S_IDLE   = 10'b00_0000_0010,
      S_FETCH  = 10'b00_0000_0100,
      S_POP    = 10'b00_0000_1000,
      S_DECODE = 10'b00_0001_0000,
      S_RDCODE = 10'b00_0010_0000,
      S_ADD    = 10'b00_0100_0000,
      S_WSTART = 10'b00_1000_0000,
      S_WALK   = 10'b01_0000_0000,
      S_EMIT   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;

   always_comb begin
      state_in  = state_ff;
      reply_in  = reply_ff;
      cmd       = '0;
      req_ready = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_last) begin
               if (reply_ff) begin
                  cmd.res_ld     = 1'b1;
                  cmd.res_status = gif_lzw_pkg::ST_RESTARTED;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  gif_lzw_pkg::FN_PUSH: begin
                     cmd.push       = 1'b1;
                     cmd.res_ld     = 1'b1;
                     cmd.res_status = sts.buf_full ? gif_lzw_pkg::ST_REFUSED
                                                   : gif_lzw_pkg::ST_ACCEPTED;
                     state_in       = S_EMIT;
                  end
                  gif_lzw_pkg::FN_FETCH: state_in = S_FETCH;
                  gif_lzw_pkg::FN_RESTART: begin
                     cmd.restart = 1'b1;
                     if (sts.size_ok) begin
                        reply_in = 1'b1;
                        state_in = S_SWEEP;
                     end else begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = gif_lzw_pkg::ST_RESTARTED;
                        state_in       = S_EMIT;
                     end
                  end
                  default: begin
                     cmd.res_ld     = 1'b1;
                     cmd.res_status = gif_lzw_pkg::ST_ERROR;
                     state_in       = S_EMIT;
                  end
               endcase
            end
         end
         S_FETCH: begin
            if (sts.failed) begin
               cmd.clear_sp   = 1'b1;
               cmd.res_ld     = 1'b1;
               cmd.res_status = gif_lzw_pkg::ST_ERROR;
               state_in       = S_EMIT;
            end else if (sts.sp_nz) begin
               cmd.pop  = 1'b1;
               state_in = S_POP;
            end else if (sts.ended) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = gif_lzw_pkg::ST_END;
               state_in       = S_EMIT;
            end else if (sts.no_code) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = gif_lzw_pkg::ST_NEED;
               state_in       = S_EMIT;
            end else begin
               cmd.take_code = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_POP: begin
            cmd.res_ld     = 1'b1;
            cmd.res_pix    = 1'b1;
            cmd.res_status = gif_lzw_pkg::ST_PIXEL;
            state_in       = S_EMIT;
         end
         S_DECODE: begin
            state_in = S_FETCH;
            if (sts.is_end) begin
               cmd.set_ended = 1'b1;
            end else if (sts.is_clear) begin
               cmd.do_clear = 1'b1;
            end else if (sts.after_clear) begin
               cmd.clr_after = 1'b1;
               if (sts.code_ge_nf) begin
                  cmd.set_failed = 1'b1;
               end else begin
                  cmd.walk_code = 1'b1;
                  cmd.set_prev  = 1'b1;
                  state_in      = S_WSTART;
               end
            end else if (!sts.code_ge_nf) begin
               cmd.rd_sel  = gif_lzw_pkg::RD_CODE;
               cmd.set_kwk = 1'b1;
               state_in    = S_RDCODE;
            end else if (sts.prev_ge_nf) begin
               cmd.set_failed = 1'b1;
            end else if (sts.tbl_full) begin
               cmd.set_prev = 1'b1;
            end else begin
               cmd.rd_sel  = gif_lzw_pkg::RD_PREV;
               cmd.set_kwk = 1'b1;
               cmd.kwk_val = 1'b1;
               state_in    = S_ADD;
            end
         end
         S_RDCODE: begin
            cmd.set_ch = 1'b1;
            if (sts.tbl_full) begin
               cmd.walk_code = 1'b1;
               cmd.set_prev  = 1'b1;
               state_in      = S_WSTART;
            end else if (sts.prev_ge_nf) begin
               cmd.set_failed = 1'b1;
               state_in       = S_FETCH;
            end else begin
               cmd.rd_sel = gif_lzw_pkg::RD_PREV;
               state_in   = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add_wr   = 1'b1;
            cmd.set_prev = 1'b1;
            state_in     = S_WSTART;
         end
         S_WSTART: begin
            cmd.rd_sel = gif_lzw_pkg::RD_WALK;
            state_in   = S_WALK;
         end
         S_WALK: begin
            if (sts.sp_full) begin
               state_in = S_FETCH;
            end else begin
               cmd.push_char = 1'b1;
               if (sts.len_le1) state_in = S_FETCH;
               else cmd.rd_sel = gif_lzw_pkg::RD_PARENT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

   `GLD_ASSERT_NXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != S_IDLE)
   `GLD_ASSERT_IMP(a_no_push_when_full, cmd.push_char, !sts.sp_full)
   `GLD_ASSERT_IMP(a_add_has_room, cmd.add_wr, !sts.tbl_full && !sts.prev_ge_nf)
   `GLD_ASSERT_NXT(a_pop_then_pixel, cmd.pop, state_ff == S_POP)
endmodule
`default_nettype wire
